@@ src/bcrp_pkg.sv @@
package bcrp_pkg;

   // Fraction width of saturations and permeabilities (unsigned Q0.24).
   localparam int FRAC_BITS = 24;
   localparam int PORE_W    = 20;
   localparam int CSR_W     = 24;
   localparam int CSR_IDX_W = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_RESIDUAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PORE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WETTING  = 2'd2;

   localparam logic [FRAC_BITS-1:0] RESIDUAL_RST = 24'd838861;
   localparam logic [PORE_W-1:0]    PORE_RST     = 20'd131072;
   localparam logic                 WETTING_RST  = 1'b1;

   localparam logic [FRAC_BITS:0] ONE_F = (FRAC_BITS + 1)'(1) << FRAC_BITS;
   localparam int SE_MIN_I = ((1 << FRAC_BITS) + 500000) / 1000000;
   localparam logic [FRAC_BITS-1:0] SE_MIN = FRAC_BITS'(SE_MIN_I);
   localparam logic [FRAC_BITS-1:0] SE_MAX = FRAC_BITS'((1 << FRAC_BITS) - SE_MIN_I);

   // Exponent format (Q.24) and the log / exp internal formats.
   localparam int EXP_FRAC  = 24;
   localparam int EXP_W     = 42;
   localparam int HALF_W    = EXP_W / 2;
   localparam int LOG_BITS  = 30;
   localparam int WHOLE_W   = 6;
   localparam int M_W       = 5;
   localparam int A_W       = LOG_BITS + M_W;
   localparam int POW_W     = FRAC_BITS + 2;
   localparam int SHIFT_OFS = LOG_BITS - FRAC_BITS;
   localparam int EXP_ZERO_WHOLE = 62 - SHIFT_OFS;
   localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

   localparam logic [EXP_W-1:0] TWO_OVER_RST =
      EXP_W'(((64'd1 << 41) + 64'(PORE_RST / 2)) / 64'(PORE_RST));
   localparam logic [EXP_W-1:0] E1_BASE = EXP_W'(3) << EXP_FRAC;
   localparam logic [EXP_W-1:0] E2_BASE = EXP_W'(1) << EXP_FRAC;
   localparam int DIV_STEPS = EXP_W;

   // Pipeline depths.
   localparam int TAYLOR_TERMS = 15;
   localparam int EXP_LAT      = 2 + 3 * TAYLOR_TERMS;
   localparam int DIV_STAGES   = FRAC_BITS;
   localparam int LOG_STAGES   = LOG_BITS;
   localparam int LATENCY      = 1 + DIV_STAGES + 1 + LOG_STAGES + 3 + EXP_LAT + 2;

   typedef struct packed {
      logic                zero;
      logic [WHOLE_W-1:0]  whole;
      logic [LOG_BITS-1:0] frac;
   } exp_arg_type;

   // Output floor at SE_MIN and saturation just below one.
   function automatic logic [FRAC_BITS-1:0] limit_out(input logic [POW_W-1:0] v);
      logic [FRAC_BITS-1:0] r;
      if (v < POW_W'(SE_MIN)) begin
         r = SE_MIN;
      end else if (v > POW_W'(ONE_F - 1'b1)) begin
         r = {FRAC_BITS{1'b1}};
      end else begin
         r = v[FRAC_BITS-1:0];
      end
      return r;
   endfunction

endpackage

@@ src/bcrp_exp2.sv @@
module bcrp_exp2 (
   input  logic                                 clock,
   input  bcrp_pkg::exp_arg_type                arg,
   output logic [bcrp_pkg::POW_W-1:0]           power
);

   localparam int LB    = bcrp_pkg::LOG_BITS;
   localparam int TERMS = bcrp_pkg::TAYLOR_TERMS;

   typedef struct packed {
      logic                          zero;
      logic [bcrp_pkg::WHOLE_W-1:0]  whole;
      logic [LB-1:0]                 w;
      logic [31:0]                   even;
      logic [31:0]                   odd;
   } ctx_type;

   ctx_type        ctx_ff   [0:TERMS];
   logic [LB:0]    term_ff  [0:TERMS];
   ctx_type        ctx_a_ff [0:TERMS-1];
   ctx_type        ctx_b_ff [0:TERMS-1];
   logic [LB-1:0]  x_ff     [0:TERMS-1];
   logic [LB-1:0]  xb_ff    [0:TERMS-1];
   logic [LB-1:0]  q0_ff    [0:TERMS-1];

   logic [61:0]    w_prod;
   ctx_type        ctx0_in;

   // w = frac(t) * ln2, the argument of exp(-w).
   always_comb begin
      w_prod        = 62'(arg.frac) * 62'(bcrp_pkg::LN2_Q32);
      ctx0_in.zero  = arg.zero;
      ctx0_in.whole = arg.whole;
      ctx0_in.w     = w_prod[61:32];
      ctx0_in.even  = 32'(1) << LB;
      ctx0_in.odd   = '0;
   end

   always_ff @(posedge clock) begin
      ctx_ff[0]  <= ctx0_in;
      term_ff[0] <= (LB + 1)'(1) << LB;
   end

   // Each Taylor term takes three stages: multiply by w, multiply by 1/k, correct.
   for (genvar g = 0; g < TERMS; g++) begin : g_term
      localparam int K = g + 1;
      localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);

      logic [60:0]   tw_prod;
      logic [62:0]   xm_prod;
      logic [33:0]   qk;
      logic [LB-1:0] rmd;
      logic [LB-1:0] q;
      ctx_type       ctx_in;

      assign tw_prod = 61'(term_ff[g]) * 61'(ctx_ff[g].w);
      assign xm_prod = 63'(x_ff[g]) * 63'(RECIP);
      assign qk      = 34'(q0_ff[g]) * 34'(K);
      assign rmd     = xb_ff[g] - qk[LB-1:0];
      assign q       = (rmd >= LB'(K)) ? q0_ff[g] + 1'b1 : q0_ff[g];

      always_comb begin
         ctx_in = ctx_b_ff[g];
         if ((K % 2) == 1) begin
            ctx_in.odd = ctx_b_ff[g].odd + 32'(q);
         end else begin
            ctx_in.even = ctx_b_ff[g].even + 32'(q);
         end
      end

      always_ff @(posedge clock) begin
         ctx_a_ff[g]  <= ctx_ff[g];
         x_ff[g]      <= tw_prod[2*LB-1:LB];
         ctx_b_ff[g]  <= ctx_a_ff[g];
         xb_ff[g]     <= x_ff[g];
         q0_ff[g]     <= xm_prod[LB+31:32];
         ctx_ff[g+1]  <= ctx_in;
         term_ff[g+1] <= (LB + 1)'(q);
      end
   end

   logic [31:0]                  diff;
   logic [6:0]                   shamt;
   logic [33:0]                  rnd;
   logic [33:0]                  rsum;
   logic [33:0]                  shr;
   logic [bcrp_pkg::POW_W-1:0]   power_in;
   logic [bcrp_pkg::POW_W-1:0]   power_ff;

   // Scale by 2^-whole and round half up into Q0.24.
   always_comb begin
      diff  = (ctx_ff[TERMS].even > ctx_ff[TERMS].odd) ?
              ctx_ff[TERMS].even - ctx_ff[TERMS].odd : '0;
      shamt = 7'(ctx_ff[TERMS].whole) + 7'(bcrp_pkg::SHIFT_OFS);
      rnd   = 34'(1) << (shamt - 7'd1);
      rsum  = 34'(diff) + rnd;
      shr   = rsum >> shamt;
      if (ctx_ff[TERMS].zero ||
          ctx_ff[TERMS].whole >= bcrp_pkg::WHOLE_W'(bcrp_pkg::EXP_ZERO_WHOLE)) begin
         power_in = '0;
      end else begin
         power_in = shr[bcrp_pkg::POW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      power_ff <= power_in;
   end

   assign power = power_ff;

endmodule

@@ src/brooks_corey_rel_perm.sv @@
// Brooks-Corey relative permeability, fully pipelined.
// Each accepted transaction strobes rsp_valid once it has passed through the whole pipeline.
// Throughput: one transaction per clock while busy is low; the depth is set by the 24-stage divider,
// the 30 squaring stages of log2 and the 45 Taylor stages of each exp2 unit.
// Writing pore_index holds busy high while 2/lambda is divided out.
// Reset is synchronous and active high; the receiver cannot stall results.
module brooks_corey_rel_perm (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [bcrp_pkg::FRAC_BITS-1:0]        req_first_fraction,
   input  logic [bcrp_pkg::FRAC_BITS-1:0]        req_second_fraction,
   output logic                                  rsp_valid,
   output logic [bcrp_pkg::FRAC_BITS-1:0]        rsp_first_perm,
   output logic [bcrp_pkg::FRAC_BITS-1:0]        rsp_second_perm,
   input  logic                                  csr_we,
   input  logic [bcrp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bcrp_pkg::CSR_W-1:0]            csr_wdata
);

   localparam int FB    = bcrp_pkg::FRAC_BITS;
   localparam int PW    = bcrp_pkg::PORE_W;
   localparam int EW    = bcrp_pkg::EXP_W;
   localparam int HW    = bcrp_pkg::HALF_W;
   localparam int LB    = bcrp_pkg::LOG_BITS;
   localparam int AW    = bcrp_pkg::A_W;
   localparam int MW    = bcrp_pkg::M_W;
   localparam int DS    = bcrp_pkg::DIV_STAGES;
   localparam int LS    = bcrp_pkg::LOG_STAGES;
   localparam int XL    = bcrp_pkg::EXP_LAT;
   localparam int PPW   = AW + HW;
   localparam int TOTW  = AW + EW;
   localparam int T_LIM = LB + bcrp_pkg::EXP_FRAC + bcrp_pkg::WHOLE_W;
   localparam int SQPW  = 2 * FB;
   localparam int PRODW = 2 * FB + 1;

   // ------------------------------------------------------------------
   // Configuration registers and the 2/lambda divider.
   // The exponents e1 = 3 + 2/lambda and e2 = 1 + 2/lambda are held in
   // registers, so the datapath never divides by lambda itself. A write to
   // pore_index starts a restoring divide of 2^41 + lambda/2 by lambda, one
   // quotient bit per cycle; busy is high for the whole divide.
   // ------------------------------------------------------------------
   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_DIVIDE = 2'b10
   } div_state_type;

   div_state_type   state_ff, state_in;
   logic [FB-1:0]   resid_ff, resid_in;
   logic [PW-1:0]   pore_ff, pore_in;
   logic            wet_ff, wet_in;
   logic [EW-1:0]   e1_ff, e1_in;
   logic [EW-1:0]   e2_ff, e2_in;
   logic [5:0]      cnt_ff, cnt_in;
   logic [PW-1:0]   rem_ff, rem_in;
   logic [EW-1:0]   quo_ff, quo_in;

   logic [PW-1:0]   lam;
   logic [PW-1:0]   wlam;
   logic [PW:0]     shl;
   logic [PW:0]     shl_diff;
   logic            step_ge;

   always_comb begin
      lam      = (pore_ff == '0) ? PW'(1) : pore_ff;
      wlam     = (csr_wdata[PW-1:0] == '0) ? PW'(1) : csr_wdata[PW-1:0];
      shl      = {rem_ff, quo_ff[EW-1]};
      shl_diff = shl - {1'b0, lam};
      step_ge  = (shl >= {1'b0, lam});

      state_in = state_ff;
      resid_in = resid_ff;
      pore_in  = pore_ff;
      wet_in   = wet_ff;
      e1_in    = e1_ff;
      e2_in    = e2_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;

      case (state_ff)
         ST_DIVIDE: begin
            rem_in = step_ge ? shl_diff[PW-1:0] : shl[PW-1:0];
            quo_in = {quo_ff[EW-2:0], step_ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(bcrp_pkg::DIV_STEPS - 1)) begin
               state_in = ST_IDLE;
               e1_in    = quo_in + bcrp_pkg::E1_BASE;
               e2_in    = quo_in + bcrp_pkg::E2_BASE;
            end
         end
         default: begin
         end
      endcase

      // A new pore index restarts the divide, even over one in progress.
      if (csr_we) begin
         case (csr_index)
            bcrp_pkg::CSR_RESIDUAL: begin
               resid_in = csr_wdata[FB-1:0];
            end
            bcrp_pkg::CSR_PORE: begin
               pore_in  = csr_wdata[PW-1:0];
               quo_in   = (EW'(1) << (EW - 1)) + EW'(wlam >> 1);
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIVIDE;
            end
            bcrp_pkg::CSR_WETTING: begin
               wet_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         resid_ff <= bcrp_pkg::RESIDUAL_RST;
         pore_ff  <= bcrp_pkg::PORE_RST;
         wet_ff   <= bcrp_pkg::WETTING_RST;
         e1_ff    <= bcrp_pkg::TWO_OVER_RST + bcrp_pkg::E1_BASE;
         e2_ff    <= bcrp_pkg::TWO_OVER_RST + bcrp_pkg::E2_BASE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         resid_ff <= resid_in;
         pore_ff  <= pore_in;
         wet_ff   <= wet_in;
         e1_ff    <= e1_in;
         e2_ff    <= e2_in;
         cnt_ff   <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy = (state_ff == ST_DIVIDE);

   // ------------------------------------------------------------------
   // Entry stage: pick the wetting fraction and subtract Sr. A fraction at
   // or below Sr gives a zero numerator, which the clamp later lifts.
   // ------------------------------------------------------------------
   logic            accept;
   logic [FB-1:0]   sw;
   logic [FB-1:0]   num_in;
   logic [FB:0]     den;

   logic            pv_ff [0:DS];
   logic [FB-1:0]   pr_ff [0:DS];
   logic [FB-1:0]   pq_ff [0:DS];

   assign accept = start && !busy;
   assign sw     = wet_ff ? req_first_fraction : req_second_fraction;
   assign num_in = (sw > resid_ff) ? sw - resid_ff : '0;
   assign den    = bcrp_pkg::ONE_F - (FB + 1)'(resid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff[0] <= 1'b0;
      end else begin
         pv_ff[0] <= accept;
      end
      pr_ff[0] <= num_in;
      pq_ff[0] <= '0;
   end

   // ------------------------------------------------------------------
   // Se = (Sw - Sr) * 2^24 / (1 - Sr): restoring divider, one quotient bit
   // per stage. The numerator is always below the divisor, so only the
   // 24 fractional quotient bits are produced.
   // ------------------------------------------------------------------
   for (genvar g = 0; g < DS; g++) begin : g_div
      logic [FB:0]   tt;
      logic [FB:0]   tdiff;
      logic          ge;

      assign tt    = {pr_ff[g], 1'b0};
      assign tdiff = tt - den;
      assign ge    = (tt >= den);

      always_ff @(posedge clock) begin
         if (reset) begin
            pv_ff[g+1] <= 1'b0;
         end else begin
            pv_ff[g+1] <= pv_ff[g];
         end
         pr_ff[g+1] <= ge ? tdiff[FB-1:0] : tt[FB-1:0];
         pq_ff[g+1] <= {pq_ff[g][FB-2:0], ge};
      end
   end

   // ------------------------------------------------------------------
   // Clamp Se into [1e-6, 1 - 1e-6] and normalise it for the log: the
   // leading one goes to bit 30 of a Q1.30 mantissa.
   // ------------------------------------------------------------------
   logic [FB-1:0]   se_c;
   logic [MW-1:0]   lead;
   logic [FB-1:0]   norm;

   logic            lg_v_ff  [0:LS];
   logic [LB:0]     lg_u_ff  [0:LS];
   logic [LB-1:0]   lg_f_ff  [0:LS];
   logic [MW-1:0]   lg_m_ff  [0:LS];
   logic [FB-1:0]   lg_se_ff [0:LS];

   always_comb begin
      if (pq_ff[DS] < bcrp_pkg::SE_MIN) begin
         se_c = bcrp_pkg::SE_MIN;
      end else if (pq_ff[DS] > bcrp_pkg::SE_MAX) begin
         se_c = bcrp_pkg::SE_MAX;
      end else begin
         se_c = pq_ff[DS];
      end
      lead = '0;
      for (int i = 0; i < FB; i++) begin
         if (se_c[i]) begin
            lead = MW'(i);
         end
      end
      norm = se_c << (MW'(FB - 1) - lead);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lg_v_ff[0] <= 1'b0;
      end else begin
         lg_v_ff[0] <= pv_ff[DS];
      end
      lg_u_ff[0]  <= (LB + 1)'(norm) << (LB - (FB - 1));
      lg_f_ff[0]  <= '0;
      lg_m_ff[0]  <= lead;
      lg_se_ff[0] <= se_c;
   end

   // ------------------------------------------------------------------
   // Fraction of log2 by repeated squaring: one bit per stage, each stage
   // one 31 x 31 multiply.
   // ------------------------------------------------------------------
   for (genvar g = 0; g < LS; g++) begin : g_log
      logic [2*LB+1:0] sqr;
      logic [LB+1:0]   vsq;

      assign sqr = (2 * LB + 2)'(lg_u_ff[g]) * (2 * LB + 2)'(lg_u_ff[g]);
      assign vsq = sqr[2*LB+1:LB];

      always_ff @(posedge clock) begin
         if (reset) begin
            lg_v_ff[g+1] <= 1'b0;
         end else begin
            lg_v_ff[g+1] <= lg_v_ff[g];
         end
         lg_u_ff[g+1]  <= vsq[LB+1] ? vsq[LB+1:1] : vsq[LB:0];
         lg_f_ff[g+1]  <= {lg_f_ff[g][LB-2:0], vsq[LB+1]};
         lg_m_ff[g+1]  <= lg_m_ff[g];
         lg_se_ff[g+1] <= lg_se_ff[g];
      end
   end

   // ------------------------------------------------------------------
   // Stage A: |log2 Se| in Q.30, and (1 - Se)^2 in parallel.
   // ------------------------------------------------------------------
   logic [MW-1:0]   int_mag;
   logic [AW-1:0]   a_in;
   logic [FB:0]     om_full;
   logic [SQPW-1:0] sqp_in;

   logic            av_ff;
   logic [AW-1:0]   a_ff;
   logic [SQPW-1:0] sqp_ff;

   assign int_mag = MW'(FB) - lg_m_ff[LS];
   assign a_in    = {int_mag, LB'(0)} - AW'(lg_f_ff[LS]);
   assign om_full = bcrp_pkg::ONE_F - {1'b0, lg_se_ff[LS]};
   assign sqp_in  = SQPW'(om_full[FB-1:0]) * SQPW'(om_full[FB-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         av_ff <= 1'b0;
      end else begin
         av_ff <= lg_v_ff[LS];
      end
      a_ff   <= a_in;
      sqp_ff <= sqp_in;
   end

   // ------------------------------------------------------------------
   // Stage P1: a * e in two halves of the 42-bit exponent for each power,
   // and rounding of (1 - Se)^2.
   // ------------------------------------------------------------------
   logic [SQPW:0]   sq_sum;

   logic            p1v_ff;
   logic [PPW-1:0]  pp1_lo_ff, pp1_hi_ff, pp2_lo_ff, pp2_hi_ff;
   logic [FB-1:0]   sq1_ff;

   assign sq_sum = (SQPW + 1)'(sqp_ff) + ((SQPW + 1)'(1) << (FB - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         p1v_ff <= 1'b0;
      end else begin
         p1v_ff <= av_ff;
      end
      pp1_lo_ff <= PPW'(a_ff) * PPW'(e1_ff[HW-1:0]);
      pp1_hi_ff <= PPW'(a_ff) * PPW'(e1_ff[EW-1:HW]);
      pp2_lo_ff <= PPW'(a_ff) * PPW'(e2_ff[HW-1:0]);
      pp2_hi_ff <= PPW'(a_ff) * PPW'(e2_ff[EW-1:HW]);
      sq1_ff    <= sq_sum[SQPW-1:FB];
   end

   // ------------------------------------------------------------------
   // Stage P2: sum the halves. A product at or above 2^60 means the power
   // underflows to zero; otherwise t = product >> 24 splits into the whole
   // and fractional parts of the exp2 argument.
   // ------------------------------------------------------------------
   logic [TOTW-1:0]        tot1, tot2;
   bcrp_pkg::exp_arg_type  arg1_in, arg2_in;

   logic                   p2v_ff;
   bcrp_pkg::exp_arg_type  arg1_ff, arg2_ff;
   logic [FB-1:0]          sq2_ff;

   always_comb begin
      tot1 = TOTW'(pp1_lo_ff) + (TOTW'(pp1_hi_ff) << HW);
      tot2 = TOTW'(pp2_lo_ff) + (TOTW'(pp2_hi_ff) << HW);
      arg1_in.zero  = |tot1[TOTW-1:T_LIM];
      arg1_in.whole = tot1[T_LIM-1:T_LIM-bcrp_pkg::WHOLE_W];
      arg1_in.frac  = tot1[T_LIM-bcrp_pkg::WHOLE_W-1:bcrp_pkg::EXP_FRAC];
      arg2_in.zero  = |tot2[TOTW-1:T_LIM];
      arg2_in.whole = tot2[T_LIM-1:T_LIM-bcrp_pkg::WHOLE_W];
      arg2_in.frac  = tot2[T_LIM-bcrp_pkg::WHOLE_W-1:bcrp_pkg::EXP_FRAC];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2v_ff <= 1'b0;
      end else begin
         p2v_ff <= p1v_ff;
      end
      arg1_ff <= arg1_in;
      arg2_ff <= arg2_in;
      sq2_ff  <= sq1_ff;
   end

   // ------------------------------------------------------------------
   // Two exp2 units: krw = Se^e1 and p2 = Se^e2. Valid and (1 - Se)^2
   // travel alongside through a delay line of the same depth.
   // ------------------------------------------------------------------
   logic [bcrp_pkg::POW_W-1:0] pw1, pw2;

   bcrp_exp2 u_exp_krw (
      .clock (clock),
      .arg   (arg1_ff),
      .power (pw1)
   );

   bcrp_exp2 u_exp_p2 (
      .clock (clock),
      .arg   (arg2_ff),
      .power (pw2)
   );

   logic            dl_v_ff  [0:XL-1];
   logic [FB-1:0]   dl_sq_ff [0:XL-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dl_v_ff[0] <= 1'b0;
      end else begin
         dl_v_ff[0] <= p2v_ff;
      end
      dl_sq_ff[0] <= sq2_ff;
   end

   for (genvar g = 1; g < XL; g++) begin : g_dly
      always_ff @(posedge clock) begin
         if (reset) begin
            dl_v_ff[g] <= 1'b0;
         end else begin
            dl_v_ff[g] <= dl_v_ff[g-1];
         end
         dl_sq_ff[g] <= dl_sq_ff[g-1];
      end
   end

   // ------------------------------------------------------------------
   // Stage O1: krn product (1 - Se)^2 * (1 - min(p2, 1)).
   // ------------------------------------------------------------------
   logic [FB:0]                 p2c;
   logic [FB:0]                 onep;

   logic                        o1v_ff;
   logic [PRODW-1:0]            prod_ff;
   logic [bcrp_pkg::POW_W-1:0]  krw_ff;

   assign p2c  = (pw2 > bcrp_pkg::POW_W'(bcrp_pkg::ONE_F)) ? bcrp_pkg::ONE_F : pw2[FB:0];
   assign onep = bcrp_pkg::ONE_F - p2c;

   always_ff @(posedge clock) begin
      if (reset) begin
         o1v_ff <= 1'b0;
      end else begin
         o1v_ff <= dl_v_ff[XL-1];
      end
      prod_ff <= PRODW'(dl_sq_ff[XL-1]) * PRODW'(onep);
      krw_ff  <= pw1;
   end

   // ------------------------------------------------------------------
   // Stage O2: round krn, floor and saturate both, and route them by the
   // wetting-phase setting into the output register.
   // ------------------------------------------------------------------
   logic [PRODW-1:0] krn_sum;
   logic [FB-1:0]    krw_lim, krn_lim;

   logic             out_v_ff;
   logic [FB-1:0]    out_first_ff, out_second_ff;

   assign krn_sum = prod_ff + (PRODW'(1) << (FB - 1));
   assign krw_lim = bcrp_pkg::limit_out(krw_ff);
   assign krn_lim = bcrp_pkg::limit_out(bcrp_pkg::POW_W'(krn_sum[PRODW-1:FB]));

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= o1v_ff;
      end
      out_first_ff  <= wet_ff ? krw_lim : krn_lim;
      out_second_ff <= wet_ff ? krn_lim : krw_lim;
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_first_perm  = out_first_ff;
   assign rsp_second_perm = out_second_ff;

endmodule

@@ src/bcrp_checker.sv @@
module bcrp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [bcrp_pkg::FRAC_BITS-1:0]    rsp_first_perm,
   input logic [bcrp_pkg::FRAC_BITS-1:0]    rsp_second_perm,
   input logic                              csr_we,
   input logic [bcrp_pkg::CSR_IDX_W-1:0]    csr_index
);

   // Every accepted transaction produces its result after the pipeline depth.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(bcrp_pkg::LATENCY) rsp_valid)
      else $error("accepted transaction gave no result");

   // No result appears without a transaction accepted that long before.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, bcrp_pkg::LATENCY))
      else $error("result without a matching transaction");

   // Results respect the output floor.
   a_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_first_perm >= bcrp_pkg::SE_MIN) &&
                    (rsp_second_perm >= bcrp_pkg::SE_MIN))
      else $error("result below the floor");

   // A pore index write starts the divide.
   a_pore_busy: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_index == bcrp_pkg::CSR_PORE) |=> busy)
      else $error("pore index write did not raise busy");

   // The divide runs its full length.
   a_busy_length: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> ##(bcrp_pkg::DIV_STEPS - 1) busy)
      else $error("busy dropped before the divide finished");

endmodule

bind brooks_corey_rel_perm bcrp_checker u_bcrp_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_first_perm  (rsp_first_perm),
   .rsp_second_perm (rsp_second_perm),
   .csr_we          (csr_we),
   .csr_index       (csr_index)
);
